// ===== rtl/core/adcrc_pkg.sv =====
// Shared types, register codes and constants of the ADC register controller.
`timescale 1ns / 1ps

package adcrc_pkg;

   // Operation codes of an input item.
   localparam logic [2:0] OP_READ    = 3'd0;
   localparam logic [2:0] OP_WRITE   = 3'd1;
   localparam logic [2:0] OP_TICK    = 3'd2;
   localparam logic [2:0] OP_TRIGGER = 3'd3;
   localparam logic [2:0] OP_ACK     = 3'd4;

   // Register indexes.
   localparam logic [2:0] REG_RESULT_LO = 3'd0;
   localparam logic [2:0] REG_RESULT_HI = 3'd1;
   localparam logic [2:0] REG_CTRL_A    = 3'd2;
   localparam logic [2:0] REG_CTRL_B    = 3'd3;
   localparam logic [2:0] REG_MUX       = 3'd4;
   localparam logic [2:0] REG_DDIS      = 3'd5;

   // Bit positions in control A.
   localparam int EN_BIT   = 7;
   localparam int SC_BIT   = 6;
   localparam int ATE_BIT  = 5;
   localparam int DONE_BIT = 4;
   localparam int IE_BIT   = 3;
   // Bit positions in the mux register and control B.
   localparam int LEFT_BIT   = 5;
   localparam int MUX_HI_BIT = 5;

   localparam logic [2:0]  TRIG_FREE_RUN      = 3'd0;
   localparam logic [15:0] CONV_LENGTH_RESET  = 16'd13;
   localparam int          SAMPLE_BITS_DEFAULT = 16;

   // Gains of the mux table.
   localparam logic [7:0] GAIN_1   = 8'd1;
   localparam logic [7:0] GAIN_10  = 8'd10;
   localparam logic [7:0] GAIN_40  = 8'd40;
   localparam logic [7:0] GAIN_200 = 8'd200;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [2:0]  reg_index;
      logic [7:0]  write_data;
      logic [15:0] elapsed;
      logic [2:0]  event_source;
      logic        power_reduced;
      logic [15:0] pos_sample;
      logic [15:0] neg_sample;
   } req_type;

   typedef struct packed {
      logic [7:0] reg_byte;
      logic       irq_request;
      logic [3:0] pos_channel;
      logic [3:0] neg_channel;
      logic       busy_res;
      logic [7:0] pin_claim_mask;
   } rsp_type;

   typedef struct packed {
      logic [3:0] pos;
      logic [3:0] neg;
      logic [7:0] gain;
      logic       diff;
   } mux_map_type;

endpackage

// ===== rtl/core/adcrc_mux_decode.sv =====
// Decoder from the six-bit mux selection to channels, gain and mode.
`timescale 1ns / 1ps

module adcrc_mux_decode (
   input  logic [5:0]                sel,
   output adcrc_pkg::mux_map_type    map
);

   always_comb begin
      // Unlisted codes fall back to single-ended on the low four bits.
      map.pos  = sel[3:0];
      map.neg  = 4'd0;
      map.gain = adcrc_pkg::GAIN_1;
      map.diff = 1'b0;
      unique case (sel)
         6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25: begin
            map.pos = {1'b1, sel[2:0]};
         end
         6'h27: begin
            map.pos = 4'd13;
         end
         6'h08: begin map.pos = 4'd0; map.neg = 4'd1; map.gain = adcrc_pkg::GAIN_10; map.diff = 1'b1; end
         6'h09: begin map.pos = 4'd0; map.neg = 4'd1; map.gain = adcrc_pkg::GAIN_40; map.diff = 1'b1; end
         6'h0A: begin map.pos = 4'd1; map.neg = 4'd1; map.gain = adcrc_pkg::GAIN_10; map.diff = 1'b1; end
         6'h0B: begin map.pos = 4'd1; map.neg = 4'd1; map.gain = adcrc_pkg::GAIN_40; map.diff = 1'b1; end
         6'h0C: begin map.pos = 4'd4; map.neg = 4'd1; map.gain = adcrc_pkg::GAIN_10; map.diff = 1'b1; end
         6'h0D: begin map.pos = 4'd4; map.neg = 4'd1; map.gain = adcrc_pkg::GAIN_40; map.diff = 1'b1; end
         6'h0E: begin map.pos = 4'd5; map.neg = 4'd1; map.gain = adcrc_pkg::GAIN_10; map.diff = 1'b1; end
         6'h0F: begin map.pos = 4'd5; map.neg = 4'd1; map.gain = adcrc_pkg::GAIN_40; map.diff = 1'b1; end
         6'h10: begin map.pos = 4'd6; map.neg = 4'd1; map.gain = adcrc_pkg::GAIN_10; map.diff = 1'b1; end
         6'h11: begin map.pos = 4'd6; map.neg = 4'd1; map.gain = adcrc_pkg::GAIN_40; map.diff = 1'b1; end
         6'h12: begin map.pos = 4'd2; map.neg = 4'd1; map.gain = adcrc_pkg::GAIN_10; map.diff = 1'b1; end
         6'h13: begin map.pos = 4'd3; map.neg = 4'd1; map.gain = adcrc_pkg::GAIN_10; map.diff = 1'b1; end
         6'h14: begin map.pos = 4'd2; map.neg = 4'd1; map.gain = adcrc_pkg::GAIN_40; map.diff = 1'b1; end
         6'h15: begin map.pos = 4'd3; map.neg = 4'd1; map.gain = adcrc_pkg::GAIN_40; map.diff = 1'b1; end
         6'h28: begin map.pos = 4'd0; map.neg = 4'd1; map.gain = adcrc_pkg::GAIN_200; map.diff = 1'b1; end
         6'h29: begin map.pos = 4'd0; map.neg = 4'd1; map.gain = adcrc_pkg::GAIN_200; map.diff = 1'b1; end
         6'h2A: begin map.pos = 4'd1; map.neg = 4'd1; map.gain = adcrc_pkg::GAIN_200; map.diff = 1'b1; end
         6'h2C: begin map.pos = 4'd4; map.neg = 4'd5; map.gain = adcrc_pkg::GAIN_10; map.diff = 1'b1; end
         6'h2D: begin map.pos = 4'd4; map.neg = 4'd5; map.gain = adcrc_pkg::GAIN_40; map.diff = 1'b1; end
         6'h2E: begin map.pos = 4'd4; map.neg = 4'd5; map.gain = adcrc_pkg::GAIN_200; map.diff = 1'b1; end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/core/adcrc_convert.sv =====
// Conversion of the channel samples into the clamped ten-bit result word.
`timescale 1ns / 1ps

module adcrc_convert #(
   parameter int SAMPLE_BITS = adcrc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  adcrc_pkg::mux_map_type map,
   input  logic [15:0]            pos_sample,
   input  logic [15:0]            neg_sample,
   input  logic                   left_adjust,
   output logic [15:0]            result
);

   localparam int PROD_W  = SAMPLE_BITS + 8;
   localparam int SHIFT_D = SAMPLE_BITS - 10;
   localparam int SHIFT_S = SAMPLE_BITS - 11;

   logic [SAMPLE_BITS-1:0] ps;
   logic [SAMPLE_BITS-1:0] ns;
   logic [SAMPLE_BITS-1:0] mag;
   logic                   below;
   logic [PROD_W-1:0]      prod;
   logic [PROD_W-1:0]      q_diff;
   logic [SAMPLE_BITS-1:0] q_single;
   logic [9:0]             clamped;
   logic [9:0]             res;

   always_comb begin
      ps       = SAMPLE_BITS'(32'(pos_sample));
      ns       = SAMPLE_BITS'(32'(neg_sample));
      below    = ns > ps;
      mag      = below ? (ns - ps) : (ps - ns);
      prod     = PROD_W'(mag) * PROD_W'(map.gain);
      q_diff   = prod >> SHIFT_D;
      q_single = ps >> SHIFT_S;
      clamped  = 10'd0;
      if (map.diff) begin
         if (below) begin
            clamped = (q_diff > PROD_W'(512)) ? 10'd512 : q_diff[9:0];
            // Negative readings are stored as ten-bit two's complement.
            res = 10'd0 - clamped;
         end else begin
            res = (q_diff > PROD_W'(511)) ? 10'd511 : q_diff[9:0];
         end
      end else begin
         res = (q_single > SAMPLE_BITS'(1023)) ? 10'd1023 : q_single[9:0];
      end
      result = left_adjust ? {res, 6'd0} : {6'd0, res};
   end

endmodule

// ===== rtl/core/adcrc_out_buffer.sv =====
// Two-entry result buffer: a head register and a skid register.
`timescale 1ns / 1ps

module adcrc_out_buffer (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  adcrc_pkg::rsp_type push_data,
   output logic               full,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output adcrc_pkg::rsp_type rsp_payload
);

   adcrc_pkg::rsp_type head_ff;
   adcrc_pkg::rsp_type head_in;
   adcrc_pkg::rsp_type skid_ff;
   adcrc_pkg::rsp_type skid_in;
   logic               head_valid_ff;
   logic               head_valid_in;
   logic               skid_valid_ff;
   logic               skid_valid_in;
   logic               pop;

   assign pop         = head_valid_ff && !rsp_stall;
   assign full        = skid_valid_ff;
   assign rsp_valid   = head_valid_ff;
   assign rsp_payload = head_ff;

   always_comb begin
      head_in       = head_ff;
      skid_in       = skid_ff;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (push) begin
         if (!head_valid_ff || (pop && !skid_valid_ff)) begin
            head_in       = push_data;
            head_valid_in = 1'b1;
         end else if (pop) begin
            // Skid moves up while the new result takes its place.
            head_in = skid_ff;
            skid_in = push_data;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   // The skid register only ever fills behind an occupied head.
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry without head entry");

   // A push is never offered when both entries are occupied.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !pop |-> !push)
      else $error("result pushed into full buffer");

endmodule

// ===== rtl/core/adc_register_controller.sv =====
// Top level of the ADC register controller: register file, conversion control, result path.
`timescale 1ns / 1ps

// Usage:
// The req channel carries one operation per transfer (read, write, tick with
// channel samples, trigger event, interrupt acknowledge). Every accepted item
// produces exactly one rsp transfer holding the read byte and the controller
// status after the operation. Both channels use valid and stall: a transfer
// happens at a clock edge where valid is high and stall is low.
// An accepted item is held in the input register until the result buffer has
// room, is then applied to the register state and lands in the result buffer,
// and its result is offered once it reaches the head of the buffer. Throughput
// is one item per cycle while the result buffer is not full; the rate is
// set by the single pass from input register to result buffer, with one
// sample-times-gain multiply in that path.
// The result buffer holds two results. While rsp_stall is high, items keep
// entering until the buffer and the input register are full; then req_stall
// rises and stays high until the receiver takes a result.
// The csr port writes the conversion length; csr_ready is always high. Write
// it only while no item is in flight. Synchronous reset clears the register file
// and conversion state, empties both stages and sets the conversion length to thirteen.
module adc_register_controller #(
   parameter int SAMPLE_BITS = adcrc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  adcrc_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output adcrc_pkg::rsp_type rsp_payload,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [15:0]        csr_data
);

   adcrc_pkg::req_type     in_ff;
   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic                   req_accept;
   logic                   proc;
   logic                   full;

   logic [7:0]             ctrl_a_ff;
   logic [7:0]             ctrl_a_in;
   logic [7:0]             ctrl_b_ff;
   logic [7:0]             ctrl_b_in;
   logic [7:0]             mux_ff;
   logic [7:0]             mux_in;
   logic [7:0]             ddis_ff;
   logic [7:0]             ddis_in;
   logic [15:0]            result_ff;
   logic [15:0]            result_in;
   logic                   busy_ff;
   logic                   busy_in;
   logic [15:0]            countdown_ff;
   logic [15:0]            countdown_in;
   logic [15:0]            conv_len_ff;

   adcrc_pkg::mux_map_type cur_map;
   adcrc_pkg::mux_map_type next_map;
   logic [15:0]            conv_result;
   logic [7:0]             rd;
   logic                   done_kept;
   adcrc_pkg::rsp_type     rsp_next;

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && !req_stall;
   assign proc       = in_valid_ff && !full;
   assign req_stall  = in_valid_ff && full;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end
   end

   adcrc_mux_decode u_cur_decode (
      .sel ({ctrl_b_ff[adcrc_pkg::MUX_HI_BIT], mux_ff[4:0]}),
      .map (cur_map)
   );

   adcrc_mux_decode u_next_decode (
      .sel ({ctrl_b_in[adcrc_pkg::MUX_HI_BIT], mux_in[4:0]}),
      .map (next_map)
   );

   adcrc_convert #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_convert (
      .map         (cur_map),
      .pos_sample  (in_ff.pos_sample),
      .neg_sample  (in_ff.neg_sample),
      .left_adjust (mux_ff[adcrc_pkg::LEFT_BIT]),
      .result      (conv_result)
   );

   always_comb begin
      ctrl_a_in    = ctrl_a_ff;
      ctrl_b_in    = ctrl_b_ff;
      mux_in       = mux_ff;
      ddis_in      = ddis_ff;
      result_in    = result_ff;
      busy_in      = busy_ff;
      countdown_in = countdown_ff;
      rd           = 8'd0;
      done_kept    = ctrl_a_ff[adcrc_pkg::DONE_BIT]
                     & ~in_ff.write_data[adcrc_pkg::DONE_BIT];
      unique case (in_ff.opcode)
         adcrc_pkg::OP_READ: begin
            unique case (in_ff.reg_index)
               adcrc_pkg::REG_RESULT_LO: rd = result_ff[7:0];
               adcrc_pkg::REG_RESULT_HI: rd = result_ff[15:8];
               adcrc_pkg::REG_CTRL_A:    rd = ctrl_a_ff;
               adcrc_pkg::REG_CTRL_B:    rd = ctrl_b_ff;
               adcrc_pkg::REG_MUX:       rd = mux_ff;
               adcrc_pkg::REG_DDIS:      rd = ddis_ff;
               default:                  rd = 8'd0;
            endcase
         end
         adcrc_pkg::OP_WRITE: begin
            unique case (in_ff.reg_index)
               adcrc_pkg::REG_CTRL_A: begin
                  // The done flag is write-one-to-clear; the other bits store.
                  ctrl_a_in = in_ff.write_data;
                  ctrl_a_in[adcrc_pkg::DONE_BIT] = done_kept;
                  if (ctrl_a_ff[adcrc_pkg::EN_BIT] && !in_ff.write_data[adcrc_pkg::EN_BIT]) begin
                     busy_in = 1'b0;
                  end
                  if (in_ff.write_data[adcrc_pkg::EN_BIT] && in_ff.write_data[adcrc_pkg::SC_BIT]) begin
                     busy_in      = 1'b1;
                     countdown_in = conv_len_ff;
                  end
               end
               adcrc_pkg::REG_CTRL_B: ctrl_b_in = in_ff.write_data;
               adcrc_pkg::REG_MUX:    mux_in    = in_ff.write_data;
               adcrc_pkg::REG_DDIS:   ddis_in   = in_ff.write_data;
               default: begin
               end
            endcase
         end
         adcrc_pkg::OP_TICK: begin
            if (in_ff.power_reduced) begin
               busy_in = 1'b0;
            end else if (busy_ff && ctrl_a_ff[adcrc_pkg::EN_BIT]) begin
               if (in_ff.elapsed >= countdown_ff) begin
                  result_in = conv_result;
                  ctrl_a_in[adcrc_pkg::SC_BIT]   = 1'b0;
                  ctrl_a_in[adcrc_pkg::DONE_BIT] = 1'b1;
                  busy_in = 1'b0;
                  // Free-running mode starts the next conversion right away.
                  if (ctrl_a_ff[adcrc_pkg::ATE_BIT] && ctrl_b_ff[2:0] == adcrc_pkg::TRIG_FREE_RUN) begin
                     busy_in      = 1'b1;
                     countdown_in = conv_len_ff;
                     ctrl_a_in[adcrc_pkg::SC_BIT] = 1'b1;
                  end
               end else begin
                  countdown_in = countdown_ff - in_ff.elapsed;
               end
            end
         end
         adcrc_pkg::OP_TRIGGER: begin
            if (ctrl_a_ff[adcrc_pkg::ATE_BIT] && ctrl_a_ff[adcrc_pkg::EN_BIT]
                && in_ff.event_source == ctrl_b_ff[2:0]) begin
               busy_in      = 1'b1;
               countdown_in = conv_len_ff;
               ctrl_a_in[adcrc_pkg::SC_BIT] = 1'b1;
            end
         end
         adcrc_pkg::OP_ACK: begin
            if (ctrl_a_ff[adcrc_pkg::IE_BIT]) begin
               ctrl_a_in[adcrc_pkg::DONE_BIT] = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_next.reg_byte       = rd;
      rsp_next.irq_request    = ctrl_a_in[adcrc_pkg::IE_BIT] & ctrl_a_in[adcrc_pkg::DONE_BIT];
      rsp_next.pos_channel    = next_map.pos;
      rsp_next.neg_channel    = next_map.diff ? next_map.neg : 4'd0;
      rsp_next.busy_res       = busy_in;
      rsp_next.pin_claim_mask = ctrl_a_in[adcrc_pkg::EN_BIT] ? ddis_in : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         ctrl_a_ff    <= 8'd0;
         ctrl_b_ff    <= 8'd0;
         mux_ff       <= 8'd0;
         ddis_ff      <= 8'd0;
         result_ff    <= 16'd0;
         busy_ff      <= 1'b0;
         countdown_ff <= 16'd0;
         conv_len_ff  <= adcrc_pkg::CONV_LENGTH_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (proc) begin
            ctrl_a_ff    <= ctrl_a_in;
            ctrl_b_ff    <= ctrl_b_in;
            mux_ff       <= mux_in;
            ddis_ff      <= ddis_in;
            result_ff    <= result_in;
            busy_ff      <= busy_in;
            countdown_ff <= countdown_in;
         end
         if (csr_valid && csr_ready) begin
            conv_len_ff <= csr_data;
         end
      end
      if (req_accept) begin
         in_ff <= req_payload;
      end
   end

   adcrc_out_buffer u_out_buffer (
      .clock       (clock),
      .reset       (reset),
      .push        (proc),
      .push_data   (rsp_next),
      .full        (full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // A conversion can only be running while the converter is enabled.
   a_busy_needs_enable: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ctrl_a_ff[adcrc_pkg::EN_BIT])
      else $error("conversion running with converter disabled");

   // The done flag is only ever set by a tick that completes a conversion.
   a_done_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(ctrl_a_ff[adcrc_pkg::DONE_BIT]) |->
         $past(proc) && $past(in_ff.opcode) == adcrc_pkg::OP_TICK)
      else $error("done flag set outside a completing tick");

endmodule
